### hw/rtl/kaph_pkg.sv
// shared types, constants and register codes of the keyed alternating product hash
`default_nettype none

package kaph_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned ProductWidth = 16;
   localparam int unsigned CsrIndexWidth = 3;

   localparam logic [ProductWidth-1:0] HashModulus = 16'hffff;
   localparam logic [ProductWidth-1:0] ProductReset = 16'h0001;

   localparam logic KeyModeSession = 1'b0;
   localparam logic KeyModePassword = 1'b1;

   localparam logic [CsrIndexWidth-1:0] CsrKeyMode = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrKeyByte0 = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrKeyByte1 = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrKeyByte2 = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrKeyByte3 = 3'd4;

   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 last_byte;
   } req_beat_type;

   typedef struct packed {
      logic [ByteWidth-1:0] hash_high;
      logic [ByteWidth-1:0] hash_low;
   } rsp_beat_type;

endpackage

`default_nettype wire

### hw/rtl/kaph_mulmod.sv
// running product times one byte, reduced modulo 65535
`default_nettype none

module kaph_mulmod (
   input  logic [kaph_pkg::ProductWidth-1:0] product,
   input  logic [kaph_pkg::ByteWidth-1:0]    data_byte,
   output logic [kaph_pkg::ProductWidth-1:0] result
);

   localparam int unsigned FullWidth = kaph_pkg::ProductWidth + kaph_pkg::ByteWidth;

   logic [FullWidth-1:0]              full;
   logic [kaph_pkg::ProductWidth:0]   sum;
   logic [kaph_pkg::ProductWidth:0]   modulus_wide;

   // 2^16 is 1 mod 65535, so the upper byte folds onto the lower half
   always_comb begin
      full = FullWidth'(product) * FullWidth'(data_byte);
      modulus_wide = {1'b0, kaph_pkg::HashModulus};
      sum = {{(kaph_pkg::ProductWidth + 1 - kaph_pkg::ByteWidth){1'b0}},
             full[FullWidth-1:kaph_pkg::ProductWidth]}
          + {1'b0, full[kaph_pkg::ProductWidth-1:0]};
      if (sum >= modulus_wide) begin
         result = kaph_pkg::ProductWidth'(sum - modulus_wide);
      end else begin
         result = sum[kaph_pkg::ProductWidth-1:0];
      end
   end

endmodule

`default_nettype wire

### hw/rtl/keyed_alternating_product_hash_core.sv
// top level of the keyed alternating product hash
//
// message bytes arrive on the req_ channel, one beat per byte, with
// last_byte set on the final byte of a message. a beat is taken at a
// clock edge where req_valid is high and req_stall is low. each message
// yields one rsp_ beat holding the keyed hash high and low bytes; bytes
// without last_byte yield nothing.
// a last byte's result goes to the output register once it is free.
// throughput: one byte per cycle while req_stall is low, set by the
// product feedback through the single 16x8 multiplier and modulo fold.
// the csr_ port writes key_mode and the four key bytes; it is always
// ready and should only be written while no message is in flight.
// a stalled result is held in the output register; non-last bytes keep
// flowing past it, and a further last byte waits in the input register,
// which raises req_stall.
// reset (synchronous, active high) clears the keys, empties both
// registers and restarts the products at one with even parity.
`default_nettype none

module keyed_alternating_product_hash_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  kaph_pkg::req_beat_type               req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output kaph_pkg::rsp_beat_type               rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [kaph_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [kaph_pkg::ByteWidth-1:0]       csr_wdata
);

   logic                               in_valid_ff, in_valid_in;
   kaph_pkg::req_beat_type             in_beat_ff, in_beat_in;
   logic [kaph_pkg::ProductWidth-1:0]  even_ff, even_in;
   logic [kaph_pkg::ProductWidth-1:0]  odd_ff, odd_in;
   logic                               parity_ff, parity_in;
   logic                               out_valid_ff, out_valid_in;
   kaph_pkg::rsp_beat_type             out_beat_ff, out_beat_in;

   logic                               key_mode_ff;
   logic [kaph_pkg::ByteWidth-1:0]     key0_ff, key1_ff, key2_ff, key3_ff;

   logic                               out_free;
   logic                               advance;
   logic                               accept;
   logic [kaph_pkg::ProductWidth-1:0]  mul_operand;
   logic [kaph_pkg::ProductWidth-1:0]  mul_result;
   logic [kaph_pkg::ProductWidth-1:0]  new_even, new_odd;
   logic [kaph_pkg::ProductWidth-1:0]  mixed, folded;
   logic [kaph_pkg::ByteWidth-1:0]     mask_high, mask_low;

   kaph_mulmod u_mulmod (
      .product   (mul_operand),
      .data_byte (in_beat_ff.data_byte),
      .result    (mul_result)
   );

   // handshake
   always_comb begin
      out_free = !out_valid_ff || !rsp_stall;
      advance = in_valid_ff && (!in_beat_ff.last_byte || out_free);
      req_stall = in_valid_ff && !advance;
      accept = req_valid && !req_stall;
   end

   // product update and final fold
   always_comb begin
      mul_operand = parity_ff ? odd_ff : even_ff;
      new_even = parity_ff ? even_ff : mul_result;
      new_odd = parity_ff ? mul_result : odd_ff;
      mixed = new_even ^ new_odd;
      folded = (mixed == kaph_pkg::HashModulus) ? '0 : mixed;
      case (key_mode_ff)
         kaph_pkg::KeyModePassword: begin
            mask_high = key0_ff ^ key1_ff;
            mask_low = key2_ff ^ key3_ff;
         end
         default: begin
            mask_high = key0_ff;
            mask_low = key1_ff;
         end
      endcase
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_beat_in = in_beat_ff;
      even_in = even_ff;
      odd_in = odd_ff;
      parity_in = parity_ff;
      out_valid_in = out_valid_ff;
      out_beat_in = out_beat_ff;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      if (advance) begin
         in_valid_in = 1'b0;
         if (in_beat_ff.last_byte) begin
            even_in = kaph_pkg::ProductReset;
            odd_in = kaph_pkg::ProductReset;
            parity_in = 1'b0;
            out_valid_in = 1'b1;
            out_beat_in.hash_high = folded[kaph_pkg::ProductWidth-1:kaph_pkg::ByteWidth]
                                    ^ mask_high;
            out_beat_in.hash_low = folded[kaph_pkg::ByteWidth-1:0] ^ mask_low;
         end else begin
            even_in = new_even;
            odd_in = new_odd;
            parity_in = !parity_ff;
         end
      end

      if (accept) begin
         in_valid_in = 1'b1;
         in_beat_in = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         even_ff <= kaph_pkg::ProductReset;
         odd_ff <= kaph_pkg::ProductReset;
         parity_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         even_ff <= even_in;
         odd_ff <= odd_in;
         parity_ff <= parity_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_beat_ff <= in_beat_in;
      out_beat_ff <= out_beat_in;
   end

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_mode_ff <= kaph_pkg::KeyModeSession;
         key0_ff <= '0;
         key1_ff <= '0;
         key2_ff <= '0;
         key3_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            kaph_pkg::CsrKeyMode:  key_mode_ff <= csr_wdata[0];
            kaph_pkg::CsrKeyByte0: key0_ff <= csr_wdata;
            kaph_pkg::CsrKeyByte1: key1_ff <= csr_wdata;
            kaph_pkg::CsrKeyByte2: key2_ff <= csr_wdata;
            kaph_pkg::CsrKeyByte3: key3_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_beat_ff;

   // a last byte only leaves the input register when the result slot is free
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_beat_ff.last_byte) |-> (!out_valid_ff || !rsp_stall))
      else $error("result register overwritten");

   // message state restarts after every last byte
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_beat_ff.last_byte) |=>
         (!parity_ff && even_ff == kaph_pkg::ProductReset
          && odd_ff == kaph_pkg::ProductReset))
      else $error("message state not restarted");

   // products stay reduced
   assert property (@(posedge clock) disable iff (reset)
      (even_ff != kaph_pkg::HashModulus) && (odd_ff != kaph_pkg::HashModulus))
      else $error("product out of range");

endmodule

`default_nettype wire
